// ===== rtl/oacc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Oversampling accumulator package
// Shared constants and types for the two-channel oversampling accumulator.
// ----------------------------------------------------------------------------
package oacc_pkg;

    localparam int SAMPLE_BITS_DEF  = 12;
    localparam int MAX_ACC_LOG2_DEF = 8;
    localparam int OUT_BITS         = 16;
    localparam int CFG_BITS         = 4;
    localparam int MUX_BITS         = 4;

    localparam logic [CFG_BITS-1:0] ACC_LOG2_RESET = 4'd8;
    localparam logic [MUX_BITS-1:0] MUX_FIRST      = 4'h6;
    localparam logic [MUX_BITS-1:0] MUX_SECOND     = 4'hB;

    typedef enum logic {
        MODE_SAMPLE = 1'b0,
        MODE_READ   = 1'b1
    } oacc_mode_t;

endpackage : oacc_pkg
`default_nettype wire

// ===== rtl/two_channel_oversampling_accumulator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Two-channel oversampling accumulator
// An accepted input beat passes through the input register, then the
// result register, before it appears as its result beat.
// Throughput: one item per cycle while out_stall is low; the accumulator
// update is a single add and compare in the core stage.
// Reset: asynchronous active low; sums, count, channel and flag clear,
// acc_log2 returns to 8.
// ----------------------------------------------------------------------------
module two_channel_oversampling_accumulator
    import oacc_pkg::*;
#(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int MAX_ACC_LOG2 = MAX_ACC_LOG2_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_BITS-1:0]    cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   mode,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        read_ok,
    output logic [OUT_BITS-1:0]         first_value,
    output logic [OUT_BITS-1:0]         second_value,
    output logic [MUX_BITS-1:0]         mux_code
);

    logic                   core_blocked;
    logic                   item_valid;
    oacc_mode_t             item_mode;
    logic [SAMPLE_BITS-1:0] item_sample;

    assign cfg_ready = 1'b1;

    oacc_in_stage #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .sample       (sample),
        .core_blocked (core_blocked),
        .item_valid   (item_valid),
        .item_mode    (item_mode),
        .item_sample  (item_sample)
    );

    oacc_core #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .MAX_ACC_LOG2 (MAX_ACC_LOG2)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_mode    (item_mode),
        .item_sample  (item_sample),
        .core_blocked (core_blocked),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_ok      (read_ok),
        .first_value  (first_value),
        .second_value (second_value),
        .mux_code     (mux_code)
    );

endmodule : two_channel_oversampling_accumulator
`default_nettype wire

// ===== rtl/oacc_in_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Oversampling accumulator input stage
// Registers one input beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
module oacc_in_stage
    import oacc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   mode,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire logic                   core_blocked,
    output logic                        item_valid,
    output oacc_mode_t                  item_mode,
    output logic [SAMPLE_BITS-1:0]      item_sample
);

    logic                   valid_reg;
    logic                   valid_next;
    oacc_mode_t             mode_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   load;

    assign in_stall = valid_reg && core_blocked;
    assign load     = !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            mode_reg   <= oacc_mode_t'(mode);
            sample_reg <= sample;
        end
    end

    assign item_valid  = valid_reg;
    assign item_mode   = mode_reg;
    assign item_sample = sample_reg;

endmodule : oacc_in_stage
`default_nettype wire

// ===== rtl/oacc_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Oversampling accumulator core
// Channel sums, sample counter, ready flag, scaling and result register.
// ----------------------------------------------------------------------------
module oacc_core
    import oacc_pkg::*;
#(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int MAX_ACC_LOG2 = MAX_ACC_LOG2_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_BITS-1:0]    cfg_data,
    input  wire logic                   item_valid,
    input  wire oacc_mode_t             item_mode,
    input  wire logic [SAMPLE_BITS-1:0] item_sample,
    output logic                        core_blocked,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        read_ok,
    output logic [OUT_BITS-1:0]         first_value,
    output logic [OUT_BITS-1:0]         second_value,
    output logic [MUX_BITS-1:0]         mux_code
);

    localparam int SUM_W      = SAMPLE_BITS + MAX_ACC_LOG2;
    localparam int CNT_W      = MAX_ACC_LOG2;
    localparam int SH_W       = 5;
    localparam int OUT_OFFSET = OUT_BITS - SAMPLE_BITS;
    localparam int EXT_W      = SUM_W + OUT_BITS;

    logic [CFG_BITS-1:0] acc_log2_reg;
    logic [SUM_W-1:0]    sum0_reg, sum0_next;
    logic [SUM_W-1:0]    sum1_reg, sum1_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                chan_reg, chan_next;
    logic                ready_reg, ready_next;

    logic                out_valid_reg, out_valid_next;
    logic                read_ok_reg, read_ok_next;
    logic [OUT_BITS-1:0] first_reg, first_next;
    logic [OUT_BITS-1:0] second_reg, second_next;
    logic [MUX_BITS-1:0] mux_reg, mux_next;

    logic                take;
    logic [CFG_BITS-1:0] eff_log2;
    logic [CNT_W:0]      count_inc;
    logic [CNT_W:0]      limit;
    logic [SUM_W-1:0]    sum_cur;
    logic [SUM_W-1:0]    sum_add;
    logic [SH_W-1:0]     eff5;
    logic [SH_W-1:0]     off5;
    logic                shift_left;
    logic [SH_W-1:0]     sh_amt;
    logic [EXT_W-1:0]    ext0, ext1;
    logic [OUT_BITS-1:0] scaled0, scaled1;

    assign core_blocked = out_valid_reg && out_stall;
    assign take         = item_valid && !core_blocked;

    assign eff_log2 = (acc_log2_reg > CFG_BITS'(MAX_ACC_LOG2)) ?
                      CFG_BITS'(MAX_ACC_LOG2) : acc_log2_reg;
    assign limit     = (CNT_W+1)'(1) << eff_log2;
    assign count_inc = {1'b0, count_reg} + (CNT_W+1)'(1);
    assign sum_cur   = chan_reg ? sum1_reg : sum0_reg;
    assign sum_add   = sum_cur + SUM_W'(item_sample);

    assign eff5       = SH_W'(eff_log2);
    assign off5       = SH_W'(OUT_OFFSET);
    assign shift_left = eff5 < off5;
    assign sh_amt     = shift_left ? (off5 - eff5) : (eff5 - off5);

    always_comb
    begin
        ext0 = {{OUT_BITS{1'b0}}, sum0_reg};
        ext1 = {{OUT_BITS{1'b0}}, sum1_reg};
        if (shift_left)
        begin
            ext0 = ext0 << sh_amt;
            ext1 = ext1 << sh_amt;
        end
        else
        begin
            ext0 = ext0 >> sh_amt;
            ext1 = ext1 >> sh_amt;
        end
        scaled0 = ext0[OUT_BITS-1:0];
        scaled1 = ext1[OUT_BITS-1:0];
    end

    always_comb
    begin
        sum0_next    = sum0_reg;
        sum1_next    = sum1_reg;
        count_next   = count_reg;
        chan_next    = chan_reg;
        ready_next   = ready_reg;
        read_ok_next = 1'b0;
        first_next   = '0;
        second_next  = '0;

        if (take)
        begin
            unique case (item_mode)
                MODE_SAMPLE:
                begin
                    if (!ready_reg)
                    begin
                        if (chan_reg)
                        begin
                            sum1_next = sum_add;
                        end
                        else
                        begin
                            sum0_next = sum_add;
                        end
                        if (count_inc >= limit)
                        begin
                            count_next = '0;
                            if (chan_reg)
                            begin
                                chan_next  = 1'b0;
                                ready_next = 1'b1;
                            end
                            else
                            begin
                                chan_next = 1'b1;
                            end
                        end
                        else
                        begin
                            count_next = count_inc[CNT_W-1:0];
                        end
                    end
                end
                MODE_READ:
                begin
                    if (ready_reg)
                    begin
                        read_ok_next = 1'b1;
                        first_next   = scaled0;
                        second_next  = scaled1;
                        sum0_next    = '0;
                        sum1_next    = '0;
                        ready_next   = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        mux_next = chan_next ? MUX_SECOND : MUX_FIRST;

        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_log2_reg  <= ACC_LOG2_RESET;
            sum0_reg      <= '0;
            sum1_reg      <= '0;
            count_reg     <= '0;
            chan_reg      <= 1'b0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                acc_log2_reg <= cfg_data;
            end
            sum0_reg      <= sum0_next;
            sum1_reg      <= sum1_next;
            count_reg     <= count_next;
            chan_reg      <= chan_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            read_ok_reg <= read_ok_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            mux_reg     <= mux_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_ok      = read_ok_reg;
    assign first_value  = first_reg;
    assign second_value = second_reg;
    assign mux_code     = mux_reg;

endmodule : oacc_core
`default_nettype wire

// ===== tb/sv/two_channel_oversampling_accumulator_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Two-channel oversampling accumulator testbench
// Drives a table of directed beats, then random sample/read traffic over
// several acc_log2 settings. Each result beat is compared with a
// cycle-free model of the accumulator (for typed rows, with the table's
// expected result), with random stalls on both sides and one long output
// hold-off that backs up the input.
module two_channel_oversampling_accumulator_tb;
    import oacc_pkg::*;

    localparam int SUM_W      = SAMPLE_BITS_DEF + MAX_ACC_LOG2_DEF;
    localparam int HEADROOM   = OUT_BITS - SAMPLE_BITS_DEF;
    localparam int IDLE_LIMIT = 1000;
    localparam int HOLD_AT    = 300;
    localparam int HOLD_LEN   = 80;
    localparam int NPHASE     = 8;
    localparam int NROWS      = 19;

    typedef struct packed {
        logic                ok;
        logic [OUT_BITS-1:0] first_sum;
        logic [OUT_BITS-1:0] second_sum;
        logic [MUX_BITS-1:0] mux;
    } acc_result_t;

    typedef struct packed {
        logic                        wr;
        logic [CFG_BITS-1:0]         cfg;
        oacc_mode_t                  op;
        logic [SAMPLE_BITS_DEF-1:0]  smp;
        logic                        typed;
        acc_result_t                 res;
    } dir_row_t;

    localparam acc_result_t NO_DATA = '{1'b0, 16'h0000, 16'h0000, MUX_FIRST};
    localparam acc_result_t FULL_0  = '{1'b1, 16'hFFF0, 16'hFFF0, MUX_FIRST};

    // rows with typed=0 are checked against the model
    localparam dir_row_t DIR_ROWS [NROWS] = '{
        '{1'b0, 4'd0,  MODE_READ,   12'd0,    1'b1, NO_DATA},
        '{1'b0, 4'd0,  MODE_SAMPLE, 12'd4095, 1'b1, NO_DATA},
        '{1'b0, 4'd0,  MODE_SAMPLE, 12'd0,    1'b0, NO_DATA},
        '{1'b1, 4'd0,  MODE_SAMPLE, 12'd4095, 1'b0, NO_DATA},
        '{1'b0, 4'd0,  MODE_SAMPLE, 12'd1,    1'b0, NO_DATA},
        '{1'b0, 4'd0,  MODE_SAMPLE, 12'd4095, 1'b1, NO_DATA},
        '{1'b0, 4'd0,  MODE_READ,   12'd4095, 1'b0, NO_DATA},
        '{1'b0, 4'd0,  MODE_READ,   12'd0,    1'b1, NO_DATA},
        '{1'b0, 4'd0,  MODE_SAMPLE, 12'd4095, 1'b0, NO_DATA},
        '{1'b0, 4'd0,  MODE_SAMPLE, 12'd4095, 1'b0, NO_DATA},
        '{1'b0, 4'd0,  MODE_READ,   12'd0,    1'b1, FULL_0},
        '{1'b1, 4'd1,  MODE_SAMPLE, 12'd0,    1'b0, NO_DATA},
        '{1'b0, 4'd1,  MODE_SAMPLE, 12'd0,    1'b0, NO_DATA},
        '{1'b0, 4'd1,  MODE_SAMPLE, 12'd4095, 1'b0, NO_DATA},
        '{1'b0, 4'd1,  MODE_SAMPLE, 12'd4095, 1'b0, NO_DATA},
        '{1'b0, 4'd1,  MODE_READ,   12'd2730, 1'b0, NO_DATA},
        '{1'b1, 4'd8,  MODE_SAMPLE, 12'd0,    1'b0, NO_DATA},
        '{1'b0, 4'd8,  MODE_READ,   12'd0,    1'b1, NO_DATA},
        '{1'b1, 4'd4,  MODE_SAMPLE, 12'd4095, 1'b0, NO_DATA}
    };

    localparam logic [CFG_BITS-1:0] PHASE_CFG [NPHASE] = '{
        4'd3, 4'd15, 4'd1, 4'd5, 4'd0, 4'd2, 4'd4, 4'd6
    };

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_BITS-1:0]        cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    oacc_mode_t                 mode;
    logic [SAMPLE_BITS_DEF-1:0] sample;
    logic                       out_valid;
    logic                       out_stall;
    logic                       read_ok;
    logic [OUT_BITS-1:0]        first_value;
    logic [OUT_BITS-1:0]        second_value;
    logic [MUX_BITS-1:0]        mux_code;

    // accumulator model state
    logic [SUM_W-1:0]    sum_acc [2];
    int unsigned         taken;
    logic                chan;
    logic                sums_ready;
    logic [CFG_BITS-1:0] acc_sel;

    acc_result_t result_q [$];
    int          errors;
    int          beats_out;
    int          idle_cycles;
    logic        calm;
    logic        hold_done;

    two_channel_oversampling_accumulator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_ok      (read_ok),
        .first_value  (first_value),
        .second_value (second_value),
        .mux_code     (mux_code)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [OUT_BITS-1:0] scale_to_16(logic [SUM_W-1:0] s, int lg);
        logic [SUM_W+HEADROOM-1:0] v;
        v = {{HEADROOM{1'b0}}, s};
        if (lg > HEADROOM)
            v = v >> (lg - HEADROOM);
        else
            v = v << (HEADROOM - lg);
        return v[OUT_BITS-1:0];
    endfunction

    function automatic acc_result_t accumulate(oacc_mode_t op, logic [SAMPLE_BITS_DEF-1:0] smp);
        acc_result_t r;
        int          lg;
        r  = '0;
        lg = (acc_sel > MAX_ACC_LOG2_DEF) ? MAX_ACC_LOG2_DEF : int'(acc_sel);
        if (op == MODE_SAMPLE) begin
            if (!sums_ready) begin
                sum_acc[chan] = sum_acc[chan] + SUM_W'(smp);
                taken++;
                if (taken >= (1 << lg)) begin
                    taken = 0;
                    if (chan) begin
                        chan       = 1'b0;
                        sums_ready = 1'b1;
                    end
                    else begin
                        chan = 1'b1;
                    end
                end
            end
        end
        else if (sums_ready) begin
            r.ok         = 1'b1;
            r.first_sum  = scale_to_16(sum_acc[0], lg);
            r.second_sum = scale_to_16(sum_acc[1], lg);
            sum_acc[0]   = '0;
            sum_acc[1]   = '0;
            sums_ready   = 1'b0;
        end
        r.mux = chan ? MUX_SECOND : MUX_FIRST;
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_beat(oacc_mode_t op, logic [SAMPLE_BITS_DEF-1:0] smp,
                             logic typed, acc_result_t typed_res);
        acc_result_t r;
        in_valid = 1'b1;
        mode     = op;
        sample   = smp;
        do
            @(posedge clk);
        while (in_stall);
        r = accumulate(op, smp);
        result_q.push_back(typed ? typed_res : r);
        @(negedge clk);
    endtask

    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid = 1'b0;
            sample   = 12'($urandom_range(0, 4095));
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
    endtask

    task automatic write_acc_log2(logic [CFG_BITS-1:0] v);
        in_valid = 1'b0;
        while (result_q.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        acc_sel = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [SAMPLE_BITS_DEF-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    // output side: random stall bursts plus one long hold-off
    initial begin
        out_stall = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (!hold_done && beats_out >= HOLD_AT) begin
                hold_done = 1'b1;
                out_stall = 1'b1;
                repeat (HOLD_LEN) @(negedge clk);
                out_stall = 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0) begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // result checker and watchdog
    always @(posedge clk) begin
        acc_result_t e;
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
            if (out_valid && !out_stall) begin
                beats_out++;
                if (result_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat ok=%0b %h %h mux=%h",
                             $time, read_ok, first_value, second_value, mux_code);
                end
                else begin
                    e = result_q.pop_front();
                    if (read_ok !== e.ok) begin
                        errors++;
                        $display("%0t: read_ok expected %0b actual %0b",
                                 $time, e.ok, read_ok);
                    end
                    if (first_value !== e.first_sum) begin
                        errors++;
                        $display("%0t: first_value expected %h actual %h",
                                 $time, e.first_sum, first_value);
                    end
                    if (second_value !== e.second_sum) begin
                        errors++;
                        $display("%0t: second_value expected %h actual %h",
                                 $time, e.second_sum, second_value);
                    end
                    if (mux_code !== e.mux) begin
                        errors++;
                        $display("%0t: mux_code expected %h actual %h",
                                 $time, e.mux, mux_code);
                    end
                end
            end
        end
    end

    initial begin
        int         n_items;
        oacc_mode_t op;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        mode        = MODE_SAMPLE;
        sample      = '0;
        errors      = 0;
        beats_out   = 0;
        idle_cycles = 0;
        calm        = 1'b0;
        sum_acc[0]  = '0;
        sum_acc[1]  = '0;
        taken       = 0;
        chan        = 1'b0;
        sums_ready  = 1'b0;
        acc_sel     = ACC_LOG2_RESET;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < NROWS; i++) begin
            if (DIR_ROWS[i].wr)
                write_acc_log2(DIR_ROWS[i].cfg);
            maybe_gap();
            send_beat(DIR_ROWS[i].op, DIR_ROWS[i].smp, DIR_ROWS[i].typed, DIR_ROWS[i].res);
        end

        for (int p = 0; p < NPHASE; p++) begin
            write_acc_log2(PHASE_CFG[p]);
            if (p == NPHASE - 1)
                calm = 1'b1;
            n_items = (PHASE_CFG[p] >= MAX_ACC_LOG2_DEF) ? 540 : 50 + 2 * (1 << PHASE_CFG[p]);
            for (int i = 0; i < n_items; i++) begin
                // mostly fill both channels and read back once ready
                if (sums_ready)
                    op = ($urandom_range(0, 9) < 8) ? MODE_READ : MODE_SAMPLE;
                else
                    op = ($urandom_range(0, 19) == 0) ? MODE_READ : MODE_SAMPLE;
                maybe_gap();
                send_beat(op, pick_sample(), 1'b0, NO_DATA);
            end
        end

        in_valid = 1'b0;
        while (result_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
